FILE: rtl/sssc_pkg.sv
`default_nettype none

package sssc_pkg;

   localparam int SIG_COUNT   = 16;
   localparam int SIG_MAX_LEN = 29;

   localparam int LEN_WIDTH   = 5;
   localparam int COUNT_WIDTH = 5;
   localparam int SCORE_WIDTH = 7;
   localparam int SUM_WIDTH   = 9;

   typedef logic [SIG_MAX_LEN*8-1:0] sig_text_type;
   typedef logic [SIG_COUNT-1:0]     sig_mask_type;

   // Text is right-aligned: byte 0 is the final character of the signature.
   localparam sig_text_type SIG_TEXT [SIG_COUNT] = '{
      sig_text_type'("response="),
      sig_text_type'("&ump="),
      sig_text_type'("&opt="),
      sig_text_type'("varUID"),
      sig_text_type'("varDumps"),
      sig_text_type'("IsValidCC"),
      sig_text_type'("DigitsLen"),
      sig_text_type'("IsEndDataValid"),
      sig_text_type'("Track3"),
      sig_text_type'({"Win", "dowsResilienceServiceMutex"}),
      sig_text_type'({"Software\\Resilience", " Soft", "ware"}),
      sig_text_type'("Luhn"),
      sig_text_type'("check digit"),
      sig_text_type'("card number"),
      sig_text_type'("^.{1,79}^"),
      sig_text_type'(";\\d{13,19}=")
   };

   localparam logic [LEN_WIDTH-1:0] SIG_LEN [SIG_COUNT] = '{
      5'd9, 5'd5, 5'd5, 5'd6, 5'd8, 5'd9, 5'd9, 5'd14,
      5'd6, 5'd29, 5'd28, 5'd4, 5'd11, 5'd11, 5'd9, 5'd11
   };

   localparam sig_mask_type EXFIL_MASK   = 16'h0003;
   localparam sig_mask_type CARD_MASK    = 16'h0820;
   localparam sig_mask_type PERSIST_MASK = 16'h0600;

   localparam logic [SUM_WIDTH-1:0] SCORE_PER_HIT = 9'd15;
   localparam logic [SUM_WIDTH-1:0] SCORE_EXFIL   = 9'd20;
   localparam logic [SUM_WIDTH-1:0] SCORE_CARD    = 9'd25;
   localparam logic [SUM_WIDTH-1:0] SCORE_PERSIST = 9'd10;
   localparam logic [SUM_WIDTH-1:0] SCORE_CAP     = 9'd100;

   localparam logic [SCORE_WIDTH-1:0] THRESH_RESET = 7'd55;

endpackage

`default_nettype wire

FILE: rtl/signature_scan_scorer_unit.sv
`default_nettype none

// Streams a buffer one byte per beat (req_last_byte marks its final byte) and, for each buffer,
// reports the 16-bit mask of literal signatures found, four category flags, a score saturated
// at 100 and the verdict against the threshold in csr_wr_data. A byte is taken every cycle while
// the input is not stalled; a shift window of the recent bytes feeds 16 parallel comparators.
// The result passes a mask register and then a scoring register before it appears. The input
// stalls only while both registers hold results that the receiver has not taken. Window and mask
// clear after each final byte; no signature spans two buffers. The threshold is sampled when the
// score is formed and must be written only while the block is idle.
module signature_scan_scorer_unit #(
   parameter int WINDOW_BYTES = 29
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_last_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_signature_hits,
   output logic        rsp_any_signature,
   output logic        rsp_http_exfil,
   output logic        rsp_card_validation,
   output logic        rsp_mutex_persistence,
   output logic [6:0]  rsp_total_score,
   output logic        rsp_likely_scraper,
   input  wire         csr_wr_en,
   input  wire  [6:0]  csr_wr_data
);

   localparam int HIST = WINDOW_BYTES - 1;

   logic [7:0]                 window_ff [HIST];
   logic [7:0]                 view      [WINDOW_BYTES];
   sssc_pkg::sig_mask_type     hit_mask_ff;
   sssc_pkg::sig_mask_type     hit_now;
   sssc_pkg::sig_mask_type     hit_mask_in;
   logic [6:0]                 threshold_ff;

   logic                       fin_valid_ff;
   sssc_pkg::sig_mask_type     fin_mask_ff;

   logic                       rsp_valid_ff;
   sssc_pkg::sig_mask_type     rsp_hits_ff;
   logic                       rsp_any_ff;
   logic                       rsp_exfil_ff;
   logic                       rsp_card_ff;
   logic                       rsp_persist_ff;
   logic [6:0]                 rsp_score_ff;
   logic                       rsp_likely_ff;

   logic                       req_fire;
   logic                       out_free;
   logic                       fin_free;

   logic [sssc_pkg::COUNT_WIDTH-1:0] cnt_all;
   logic [sssc_pkg::COUNT_WIDTH-1:0] cnt_exfil;
   logic [sssc_pkg::COUNT_WIDTH-1:0] cnt_card;
   logic [sssc_pkg::COUNT_WIDTH-1:0] cnt_persist;
   logic [sssc_pkg::SUM_WIDTH-1:0]   score_sum;
   logic [6:0]                       score_sat;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fin_free  = !fin_valid_ff || out_free;
   assign req_ready = fin_free;
   assign req_fire  = req_valid && req_ready;

   // Oldest byte at index 0, incoming byte at the top.
   always_comb begin
      for (int j = 0; j < HIST; j++) begin
         view[j] = window_ff[j];
      end
      view[WINDOW_BYTES-1] = req_data_byte;
   end

   always_comb begin
      for (int i = 0; i < sssc_pkg::SIG_COUNT; i++) begin
         hit_now[i] = (int'(sssc_pkg::SIG_LEN[i]) <= WINDOW_BYTES);
         for (int k = 0; k < sssc_pkg::SIG_MAX_LEN; k++) begin
            if (k < int'(sssc_pkg::SIG_LEN[i])) begin
               if (view[WINDOW_BYTES-1-k] != sssc_pkg::SIG_TEXT[i][8*k +: 8]) begin
                  hit_now[i] = 1'b0;
               end
            end
         end
      end
      hit_mask_in = hit_mask_ff | hit_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < HIST; j++) begin
            window_ff[j] <= 8'd0;
         end
         hit_mask_ff <= '0;
      end else if (req_fire) begin
         if (req_last_byte) begin
            for (int j = 0; j < HIST; j++) begin
               window_ff[j] <= 8'd0;
            end
            hit_mask_ff <= '0;
         end else begin
            for (int j = 0; j < HIST; j++) begin
               window_ff[j] <= view[j+1];
            end
            hit_mask_ff <= hit_mask_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= sssc_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // Final mask of a buffer waits here for the scoring stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (fin_free) begin
         fin_valid_ff <= req_fire && req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_free && req_fire && req_last_byte) begin
         fin_mask_ff <= hit_mask_in;
      end
   end

   always_comb begin
      cnt_all     = '0;
      cnt_exfil   = '0;
      cnt_card    = '0;
      cnt_persist = '0;
      for (int i = 0; i < sssc_pkg::SIG_COUNT; i++) begin
         cnt_all     = cnt_all + sssc_pkg::COUNT_WIDTH'(fin_mask_ff[i]);
         cnt_exfil   = cnt_exfil
                     + sssc_pkg::COUNT_WIDTH'(fin_mask_ff[i] & sssc_pkg::EXFIL_MASK[i]);
         cnt_card    = cnt_card
                     + sssc_pkg::COUNT_WIDTH'(fin_mask_ff[i] & sssc_pkg::CARD_MASK[i]);
         cnt_persist = cnt_persist
                     + sssc_pkg::COUNT_WIDTH'(fin_mask_ff[i] & sssc_pkg::PERSIST_MASK[i]);
      end
      score_sum = sssc_pkg::SCORE_PER_HIT * sssc_pkg::SUM_WIDTH'(cnt_all)
                + sssc_pkg::SCORE_EXFIL   * sssc_pkg::SUM_WIDTH'(cnt_exfil)
                + sssc_pkg::SCORE_CARD    * sssc_pkg::SUM_WIDTH'(cnt_card)
                + sssc_pkg::SCORE_PERSIST * sssc_pkg::SUM_WIDTH'(cnt_persist);
      if (score_sum > sssc_pkg::SCORE_CAP) begin
         score_sat = sssc_pkg::SCORE_CAP[6:0];
      end else begin
         score_sat = score_sum[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && fin_valid_ff) begin
         rsp_hits_ff    <= fin_mask_ff;
         rsp_any_ff     <= |fin_mask_ff;
         rsp_exfil_ff   <= |(fin_mask_ff & sssc_pkg::EXFIL_MASK);
         rsp_card_ff    <= |(fin_mask_ff & sssc_pkg::CARD_MASK);
         rsp_persist_ff <= |(fin_mask_ff & sssc_pkg::PERSIST_MASK);
         rsp_score_ff   <= score_sat;
         rsp_likely_ff  <= (score_sat >= threshold_ff);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_signature_hits    = rsp_hits_ff;
   assign rsp_any_signature     = rsp_any_ff;
   assign rsp_http_exfil        = rsp_exfil_ff;
   assign rsp_card_validation   = rsp_card_ff;
   assign rsp_mutex_persistence = rsp_persist_ff;
   assign rsp_total_score       = rsp_score_ff;
   assign rsp_likely_scraper    = rsp_likely_ff;

endmodule

`default_nettype wire

FILE: tb/sv/tb_signature_scan_scorer_unit.sv
`timescale 1ns / 1ps

module tb_signature_scan_scorer_unit;

   localparam int HIST_BYTES      = 28;
   localparam int VIEW_BITS       = (HIST_BYTES + 1) * 8;
   localparam int SIG_TOTAL       = 16;
   localparam logic [6:0] THRESH_AT_RESET = 7'd55;
   localparam logic [15:0] EXFIL_SIGS   = 16'h0003;
   localparam logic [15:0] CARD_SIGS    = 16'h0820;
   localparam logic [15:0] PERSIST_SIGS = 16'h0600;
   localparam int PTS_PER_HIT     = 15;
   localparam int PTS_EXFIL       = 20;
   localparam int PTS_CARD        = 25;
   localparam int PTS_PERSIST     = 10;
   localparam int PTS_CAP         = 100;
   localparam int LONG_STALL      = 250;
   localparam int STALL_SPACING   = 900;
   localparam int SEGMENTS        = 6;
   localparam int SEGMENT_BYTES   = 210;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } scan_beat_type;

   typedef struct packed {
      sssc_pkg::sig_mask_type hits;
      logic                   any;
      logic                   exfil;
      logic                   card;
      logic                   persist;
      logic [6:0]             score;
      logic                   likely;
   } scan_verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_signature_hits;
   logic        rsp_any_signature;
   logic        rsp_http_exfil;
   logic        rsp_card_validation;
   logic        rsp_mutex_persistence;
   logic [6:0]  rsp_total_score;
   logic        rsp_likely_scraper;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = 7'd0;

   scan_beat_type    beat_q[$];
   logic [7:0]       frame_bytes[$];
   scan_verdict_type verdict_q[$];

   logic [HIST_BYTES*8-1:0] scan_hist;
   logic [15:0]             seen_mask;
   logic [6:0]              scan_thresh;
   logic [15:0]             found_now;
   int                      accepted_beats;

   int send_idle_pct = 11;
   int recv_idle_pct = 63;
   int stall_left;
   int next_stall_beat;
   int err_count = 0;
   int rsp_count = 0;
   scan_beat_type    next_beat;
   scan_verdict_type want_v;
   scan_verdict_type got_v;

   signature_scan_scorer_unit DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_last_byte         (req_last_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_signature_hits    (rsp_signature_hits),
      .rsp_any_signature     (rsp_any_signature),
      .rsp_http_exfil        (rsp_http_exfil),
      .rsp_card_validation   (rsp_card_validation),
      .rsp_mutex_persistence (rsp_mutex_persistence),
      .rsp_total_score       (rsp_total_score),
      .rsp_likely_scraper    (rsp_likely_scraper),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // text is right-aligned: byte 0 holds the final character
   function automatic void sig_pattern(input int idx, output logic [VIEW_BITS-1:0] text,
                                       output int len);
      text = '0;
      len  = 0;
      case (idx)
         0:  begin text = "response=";      len = 9;  end
         1:  begin text = "&ump=";          len = 5;  end
         2:  begin text = "&opt=";          len = 5;  end
         3:  begin text = "varUID";         len = 6;  end
         4:  begin text = "varDumps";       len = 8;  end
         5:  begin text = "IsValidCC";      len = 9;  end
         6:  begin text = "DigitsLen";      len = 9;  end
         7:  begin text = "IsEndDataValid"; len = 14; end
         8:  begin text = "Track3";         len = 6;  end
         9:  begin text = {"Win", "dowsResilienceServiceMutex"}; len = 29; end
         10: begin text = {"Software\\Resilience", " Soft", "ware"}; len = 28; end
         11: begin text = "Luhn";           len = 4;  end
         12: begin text = "check digit";    len = 11; end
         13: begin text = "card number";    len = 11; end
         14: begin text = "^.{1,79}^";      len = 9;  end
         15: begin text = ";\\d{13,19}=";   len = 11; end
         default: begin text = '0; len = 0; end
      endcase
   endfunction

   // mask of signatures whose final byte is byte 0 of view
   function automatic logic [15:0] sigs_ending_at(input logic [VIEW_BITS-1:0] view);
      logic [15:0]          m;
      logic [VIEW_BITS-1:0] text;
      int                   len;
      logic                 same;
      m = '0;
      for (int i = 0; i < SIG_TOTAL; i++) begin
         sig_pattern(i, text, len);
         same = 1'b1;
         for (int k = 0; k < len; k++) begin
            if (view[k*8 +: 8] != text[k*8 +: 8]) same = 1'b0;
         end
         if (same) m[i] = 1'b1;
      end
      return m;
   endfunction

   function automatic scan_verdict_type grade_buffer(input logic [15:0] m,
                                                     input logic [6:0] thr);
      scan_verdict_type v;
      int               pts;
      pts = PTS_PER_HIT * $countones(m) + PTS_EXFIL * $countones(m & EXFIL_SIGS)
          + PTS_CARD * $countones(m & CARD_SIGS) + PTS_PERSIST * $countones(m & PERSIST_SIGS);
      if (pts > PTS_CAP) pts = PTS_CAP;
      v.hits    = m;
      v.any     = (m != '0);
      v.exfil   = ((m & EXFIL_SIGS) != '0);
      v.card    = ((m & CARD_SIGS) != '0);
      v.persist = ((m & PERSIST_SIGS) != '0);
      v.score   = pts[6:0];
      v.likely  = (pts >= int'(thr));
      return v;
   endfunction

   // push part of a signature into the frame, optionally corrupting one character
   task automatic stage_sig(input int idx, input int first, input int count, input int flip);
      logic [VIEW_BITS-1:0] text;
      int                   len;
      logic [7:0]           b;
      sig_pattern(idx, text, len);
      for (int p = first; p < first + count && p < len; p++) begin
         b = text[(len - 1 - p)*8 +: 8];
         if (p == flip) b = b ^ 8'($urandom_range(1, 255));
         frame_bytes.insert(frame_bytes.size(), b);
      end
   endtask

   task automatic stage_full_sig(input int idx);
      stage_sig(idx, 0, HIST_BYTES + 1, -1);
   endtask

   task automatic commit_frame();
      scan_beat_type bt;
      while (frame_bytes.size() != 0) begin
         bt.data = frame_bytes.pop_front();
         bt.last = (frame_bytes.size() == 0);
         beat_q.insert(beat_q.size(), bt);
      end
   endtask

   task automatic queue_random_buffers(input int budget);
      int added;
      int target;
      int pick;
      int idx;
      int len;
      bit noise_only;
      logic [VIEW_BITS-1:0] text;
      added = 0;
      while (added < budget) begin
         target     = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 36);
         noise_only = ($urandom_range(0, 9) == 0);
         while (frame_bytes.size() < target) begin
            pick = noise_only ? 99 : $urandom_range(0, 99);
            idx  = $urandom_range(0, SIG_TOTAL - 1);
            sig_pattern(idx, text, len);
            if (pick < 45)
               stage_full_sig(idx);
            else if (pick < 60)
               stage_sig(idx, 0, $urandom_range(1, len - 1), -1);
            else if (pick < 70)
               stage_sig(idx, 0, len, $urandom_range(0, len - 1));
            else if ($urandom_range(0, 1) == 0)
               frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(32, 126)));
            else
               frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
         end
         added += frame_bytes.size();
         commit_frame();
      end
   endtask

   task automatic wait_drained(input int tail);
      while (beat_q.size() != 0 || req_valid || verdict_q.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic program_threshold(input logic [6:0] thr);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= thr;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'h00;
         req_last_byte <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_beat     = beat_q.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= next_beat.data;
            req_last_byte <= next_beat.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // scan model: mirror window, sticky mask and threshold
   always @(posedge clock) begin
      if (reset) begin
         scan_hist      <= '0;
         seen_mask      <= '0;
         scan_thresh    <= THRESH_AT_RESET;
         accepted_beats <= 0;
      end else begin
         if (csr_wr_en) scan_thresh <= csr_wr_data;
         if (req_valid && req_ready) begin
            found_now = seen_mask | sigs_ending_at({scan_hist, req_data_byte});
            accepted_beats <= accepted_beats + 1;
            if (req_last_byte) begin
               verdict_q.insert(verdict_q.size(), grade_buffer(found_now, scan_thresh));
               scan_hist <= '0;
               seen_mask <= '0;
            end else begin
               scan_hist <= {scan_hist[(HIST_BYTES-1)*8-1:0], req_data_byte};
               seen_mask <= found_now;
            end
         end
      end
   end

   // receiver: random backpressure plus periodic long hold-off while input is busy
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready       <= 1'b0;
         stall_left      <= 0;
         next_stall_beat <= 500;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (accepted_beats >= next_stall_beat && beat_q.size() > 100) begin
         rsp_ready       <= 1'b0;
         stall_left      <= LONG_STALL;
         next_stall_beat <= accepted_beats + STALL_SPACING;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_v.hits    = rsp_signature_hits;
         got_v.any     = rsp_any_signature;
         got_v.exfil   = rsp_http_exfil;
         got_v.card    = rsp_card_validation;
         got_v.persist = rsp_mutex_persistence;
         got_v.score   = rsp_total_score;
         got_v.likely  = rsp_likely_scraper;
         if (verdict_q.size() == 0) begin
            if (err_count < 10)
               $display("%0t: result %0d arrived with none expected: hits=%h score=%0d",
                        $realtime, rsp_count, got_v.hits, got_v.score);
            err_count++;
         end else begin
            want_v = verdict_q.pop_front();
            if (got_v.hits !== want_v.hits || got_v.any !== want_v.any ||
                got_v.exfil !== want_v.exfil || got_v.card !== want_v.card ||
                got_v.persist !== want_v.persist || got_v.score !== want_v.score ||
                got_v.likely !== want_v.likely) begin
               if (err_count < 10) begin
                  $display("%0t: result %0d expected hits=%h any=%b exfil=%b card=%b",
                           $realtime, rsp_count, want_v.hits, want_v.any, want_v.exfil,
                           want_v.card);
                  $display("%0t: result %0d expected persist=%b score=%0d likely=%b",
                           $realtime, rsp_count, want_v.persist, want_v.score,
                           want_v.likely);
                  $display("%0t: result %0d actual   hits=%h any=%b exfil=%b card=%b",
                           $realtime, rsp_count, got_v.hits, got_v.any, got_v.exfil,
                           got_v.card);
                  $display("%0t: result %0d actual   persist=%b score=%0d likely=%b",
                           $realtime, rsp_count, got_v.persist, got_v.score,
                           got_v.likely);
               end
               err_count++;
            end
         end
         rsp_count++;
      end
   end

   initial begin
      logic [6:0] thr_plan [SEGMENTS];
      thr_plan[0] = 7'd0;
      thr_plan[1] = 7'd100;
      thr_plan[2] = 7'd127;
      thr_plan[3] = 7'd101;
      thr_plan[4] = 7'($urandom_range(0, 127));
      thr_plan[5] = 7'($urandom_range(1, 99));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // one-byte buffers at the byte extremes
      frame_bytes.insert(frame_bytes.size(), 8'h00);
      commit_frame();
      frame_bytes.insert(frame_bytes.size(), 8'hFF);
      commit_frame();
      // each signature alone, completing on the flagged byte
      for (int i = 0; i < SIG_TOTAL; i++) begin
         stage_full_sig(i);
         commit_frame();
      end
      // every signature in one buffer: score saturates
      for (int i = 0; i < SIG_TOTAL; i++) begin
         stage_full_sig(i);
         frame_bytes.insert(frame_bytes.size(), 8'hFF);
      end
      commit_frame();
      // split across a buffer boundary: no hit on either side
      stage_sig(0, 0, 4, -1);
      commit_frame();
      stage_sig(0, 4, 5, -1);
      commit_frame();
      // longest signature behind filler, spanning the full window
      for (int k = 0; k < 20; k++) frame_bytes.insert(frame_bytes.size(), 8'h80 + 8'(k));
      stage_full_sig(9);
      frame_bytes.insert(frame_bytes.size(), 8'h00);
      commit_frame();
      // score lands exactly on the cap
      stage_full_sig(0);
      stage_full_sig(5);
      stage_full_sig(9);
      commit_frame();
      // repeat hit counts once; caret text that is not the literal misses
      stage_full_sig(8);
      stage_full_sig(8);
      frame_bytes.insert(frame_bytes.size(), "^");
      frame_bytes.insert(frame_bytes.size(), "a");
      frame_bytes.insert(frame_bytes.size(), "^");
      commit_frame();
      wait_drained(4);

      for (int s = 0; s < SEGMENTS; s++) begin
         if (s < 2) begin
            send_idle_pct = 11;
            recv_idle_pct = 63;
         end else if (s < 4) begin
            send_idle_pct = 63;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         program_threshold(thr_plan[s]);
         queue_random_buffers(SEGMENT_BYTES);
         wait_drained(4);
      end

      wait_drained(20);
      if (err_count == 0 && verdict_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
rtl/sssc_pkg.sv
rtl/signature_scan_scorer_unit.sv
tb/sv/tb_signature_scan_scorer_unit.sv
